// File: rtl/sm3_pkg.sv
package sm3_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [31:0] SM3_T_LOW  = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7A879D8A;
    localparam logic [31:0] SM3_PAD_WORD = {8'h80, 24'h000000};

    localparam int ROUNDS = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS = 56;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

endpackage

// File: rtl/sm3_cf.sv
module sm3_cf
    import sm3_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_v,
    input  logic [511:0] i_blk,
    output logic         o_done,
    output logic [255:0] o_v
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_w [16];
    logic [31:0] r_t;
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_done;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new, n_t;
    logic        first_half;

    always_comb begin
        first_half = (r_rnd < 6'd16);
        a12 = rotl32(r_a, 12);
        ss1 = rotl32(a12 + r_e + r_t, 7);
        ss2 = ss1 ^ a12;
        if (first_half) begin
            ff = r_a ^ r_b ^ r_c;
            gg = r_e ^ r_f ^ r_g;
        end else begin
            ff = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            gg = (r_e & r_f) | (~r_e & r_g);
        end
        tt1 = ff + r_d + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_h + ss1 + r_w[0];
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl32(r_w[13], 15)) ^ rotl32(r_w[3], 7) ^ r_w[10];
        n_t = (r_rnd == 6'd15) ? rotl32(SM3_T_HIGH, 16) : rotl32(r_t, 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'(ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= i_v;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_blk[511 - 32 * i -: 32];
            end
            r_t <= SM3_T_LOW;
        end else if (r_busy) begin
            r_d <= r_c;
            r_c <= rotl32(r_b, 9);
            r_b <= r_a;
            r_a <= tt1;
            r_h <= r_g;
            r_g <= rotl32(r_f, 19);
            r_f <= r_e;
            r_e <= perm0(tt2);
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
            r_t <= n_t;
        end
    end

    assign o_done = r_done;
    assign o_v = {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h};

endmodule

// File: rtl/sm3_hash_top.sv
// SM3 hash engine. Message words are taken one request at a time; each is
// accepted and packed, and every 64th byte starts a compression (one round per
// cycle in a single shared round unit, plus start and fold). The request carrying
// the last word adds padding and length insertion and one or two more
// compressions, after which the eight digest words are offered, word 0 first; no
// new request is taken until the last of them has been accepted.
module sm3_hash_top
    import sm3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ABSORB = 3'd1;
    localparam logic [2:0] S_PAD    = 3'd2;
    localparam logic [2:0] S_LEN    = 3'd3;
    localparam logic [2:0] S_CGO    = 3'd4;
    localparam logic [2:0] S_CWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]   r_state, n_state;
    logic [2:0]   r_ret, n_ret;
    logic [5:0]   r_off, n_off;
    logic [54:0]  r_count, n_count;
    logic [2:0]   r_rem, n_rem;
    logic [31:0]  r_word, n_word;
    logic         r_last, n_last;
    logic         r_pend, n_pend;
    logic [63:0]  r_len, n_len;
    logic [511:0] r_blk, n_blk;
    logic [255:0] r_v, n_v;
    logic [2:0]   r_ocnt, n_ocnt;

    logic [2:0]   k;
    logic [31:0]  d;
    logic [6:0]   room;
    logic [6:0]   target;
    logic [6:0]   sum;
    logic         cf_start;
    logic         cf_done;
    logic [255:0] cf_v;

    sm3_cf u_cf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cf_start),
        .i_v     (r_v),
        .i_blk   (r_blk),
        .o_done  (cf_done),
        .o_v     (cf_v)
    );

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_off    = r_off;
        n_count  = r_count;
        n_rem    = r_rem;
        n_word   = r_word;
        n_last   = r_last;
        n_pend   = r_pend;
        n_len    = r_len;
        n_v      = r_v;
        n_ocnt   = r_ocnt;
        cf_start = 1'b0;
        k        = '0;
        d        = r_word;
        target   = 7'(LEN_POS);
        room     = 7'(BLOCK_BYTES) - {1'b0, r_off};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word  = i_in.msg_word;
                    n_rem   = (i_in.word_bytes > 3'd4) ? 3'd4 : i_in.word_bytes;
                    n_last  = i_in.last_word;
                    n_state = S_ABSORB;
                end
            end
            S_ABSORB: begin
                k = (room < {4'b0, r_rem}) ? room[2:0] : r_rem;
            end
            S_PAD: begin
                d = r_pend ? SM3_PAD_WORD : '0;
                target = (r_off < 6'(LEN_POS)) ? 7'(LEN_POS) : 7'(BLOCK_BYTES);
                room = target - {1'b0, r_off};
                if (r_pend || r_off != 6'(LEN_POS)) begin
                    k = (room < 7'd4) ? room[2:0] : 3'd4;
                end
            end
            S_LEN: begin
                d = r_len[63:32];
                k = 3'd4;
            end
            S_CGO: begin
                cf_start = 1'b1;
                n_state  = S_CWAIT;
            end
            S_CWAIT: begin
                if (cf_done) begin
                    n_v     = r_v ^ cf_v;
                    n_ocnt  = '0;
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_v    = {r_v[223:0], SM3_IV[r_ocnt]};
                    n_ocnt = r_ocnt + 3'd1;
                    if (r_ocnt == 3'd7) begin
                        n_count = '0;
                        n_off   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        sum = {1'b0, r_off} + {4'b0, k};

        case (k)
            3'd1:    n_blk = {r_blk[503:0], d[31:24]};
            3'd2:    n_blk = {r_blk[495:0], d[31:16]};
            3'd3:    n_blk = {r_blk[487:0], d[31:8]};
            3'd4:    n_blk = {r_blk[479:0], d};
            default: n_blk = r_blk;
        endcase

        case (r_state)
            S_ABSORB: begin
                case (k)
                    3'd1:    n_word = {r_word[23:0], 8'h00};
                    3'd2:    n_word = {r_word[15:0], 16'h0000};
                    3'd3:    n_word = {r_word[7:0], 24'h000000};
                    3'd4:    n_word = '0;
                    default: n_word = r_word;
                endcase
                n_rem = r_rem - k;
                n_off = sum[5:0];
                if (sum == 7'(BLOCK_BYTES)) begin
                    n_count = r_count + 55'd1;
                    n_ret   = S_ABSORB;
                    n_state = S_CGO;
                end else if (r_last) begin
                    n_len   = {r_count, sum[5:0], 3'b000};
                    n_pend  = 1'b1;
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (!r_pend && r_off == 6'(LEN_POS)) begin
                    n_state = S_LEN;
                end else begin
                    n_pend = 1'b0;
                    n_off  = sum[5:0];
                    if (sum == 7'(BLOCK_BYTES)) begin
                        n_ret   = S_PAD;
                        n_state = S_CGO;
                    end
                end
            end
            S_LEN: begin
                n_len = {r_len[31:0], 32'h0};
                n_off = sum[5:0];
                if (sum == 7'(BLOCK_BYTES)) begin
                    n_ret   = S_OUT;
                    n_state = S_CGO;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_off   <= '0;
            r_count <= '0;
            r_rem   <= '0;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
            r_ocnt  <= '0;
            r_v     <= {SM3_IV[0], SM3_IV[1], SM3_IV[2], SM3_IV[3],
                        SM3_IV[4], SM3_IV[5], SM3_IV[6], SM3_IV[7]};
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_off   <= n_off;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_ocnt  <= n_ocnt;
            r_v     <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_len  <= n_len;
        r_blk  <= n_blk;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out.digest_word = r_v[255:224];
    assign o_out.digest_last = (r_ocnt == 3'd7);

endmodule

// File: rtl/sm3_hash_chk.sv
module sm3_hash_chk
    import sm3_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // A digest is never offered while a new request can be taken.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest pending");

    // Every accepted request keeps the engine busy in the cycle after it.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepted request");

    // The final digest word closes the output burst.
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.digest_last) |=> !o_out_valid)
        else $error("output continues after last digest word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled digest word changed");

endmodule

bind sm3_hash_top sm3_hash_chk u_sm3_hash_chk (.*);

// File: sim/sm3_hash_top_tb.sv
module sm3_hash_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sm3_pkg::*;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int RANDOM_ITEMS = 104;
    localparam int PHASE_ITEMS = RANDOM_ITEMS / 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    t_in  req_q[$];
    t_out digest_q[$];
    int   err_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    logic [31:0] chain_v [8];
    logic [31:0] blk_buf [16];
    int unsigned fill_bytes;
    logic [54:0] blocks_done;

    sm3_hash_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        int s;
        s = n % 32;
        if (s == 0) return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] disperse_p0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] disperse_p1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    function automatic void clear_hash_state();
        for (int k = 0; k < 8; k++) chain_v[k] = SM3_IV[k];
        for (int k = 0; k < 16; k++) blk_buf[k] = '0;
        fill_bytes = 0;
        blocks_done = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = blk_buf[j];
        for (int j = 16; j < 68; j++)
            w[j] = disperse_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15))
                 ^ rol32(w[j-13], 7) ^ w[j-6];
        a = chain_v[0]; b = chain_v[1]; c = chain_v[2]; d = chain_v[3];
        e = chain_v[4]; f = chain_v[5]; g = chain_v[6]; h = chain_v[7];
        for (int j = 0; j < 64; j++) begin
            tj = (j < 16) ? SM3_T_LOW : SM3_T_HIGH;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j % 32), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = disperse_p0(tt2);
        end
        chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
        chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
    endfunction

    function automatic void put_byte(input int unsigned pos, input logic [7:0] v);
        blk_buf[(pos >> 2) & 15][24 - 8 * (pos & 3) +: 8] = v;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        put_byte(fill_bytes, v);
        fill_bytes++;
        if (fill_bytes >= 64) begin
            compress_block();
            blocks_done = blocks_done + 55'd1;
            fill_bytes = 0;
        end
    endfunction

    function automatic void pad_and_close();
        logic [63:0] bit_len;
        bit_len = {blocks_done, 9'd0} + (64'(fill_bytes) << 3);
        put_byte(fill_bytes, PAD_BYTE);
        for (int unsigned p = fill_bytes + 1; p < 64; p++) put_byte(p, 8'h00);
        if (fill_bytes >= 56) begin
            compress_block();
            for (int k = 0; k < 16; k++) blk_buf[k] = '0;
        end
        blk_buf[14] = bit_len[63:32];
        blk_buf[15] = bit_len[31:0];
        compress_block();
    endfunction

    function automatic void predict_digest(input t_in r);
        int n;
        t_out exp_word;
        n = (r.word_bytes > 3'd4) ? 4 : int'(r.word_bytes);
        for (int i = 0; i < n; i++) absorb_byte(r.msg_word[31 - 8 * i -: 8]);
        if (r.last_word) begin
            pad_and_close();
            for (int k = 0; k < 8; k++) begin
                exp_word.digest_word = chain_v[k];
                exp_word.digest_last = (k == 7);
                digest_q.push_back(exp_word);
            end
            clear_hash_state();
        end
    endfunction

    function automatic void push_request(input logic [31:0] w, input logic [2:0] nb,
                                         input logic last);
        t_in r;
        r.msg_word = w;
        r.word_bytes = nb;
        r.last_word = last;
        req_q.push_back(r);
    endfunction

    function automatic int push_random_message();
        int len;
        logic [2:0] nb;
        len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        for (int i = 0; i < len - 1; i++) begin
            nb = ($urandom_range(99) < 85) ? 3'd4 : 3'($urandom_range(0, 7));
            push_request($urandom, nb, 1'b0);
        end
        push_request($urandom, 3'($urandom_range(0, 7)), 1'b1);
        return len;
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #1ms;
        $display("[sm3_hash_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_digest(i_in);
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in <= req_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_word;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h arrived with no digest pending", o_out.digest_word);
                    err_cnt++;
                end else begin
                    exp_word = digest_q.pop_front();
                    if (o_out.digest_word !== exp_word.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_word.digest_word, o_out.digest_word);
                        err_cnt++;
                    end
                    if (o_out.digest_last !== exp_word.digest_last) begin
                        $error("digest_last expected %b actual %b",
                               exp_word.digest_last, o_out.digest_last);
                        err_cnt++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int sent;
        clear_hash_state();

        // Empty message, then the three-byte "abc" message.
        push_request(32'h00000000, 3'd0, 1'b1);
        push_request(32'h61626300, 3'd3, 1'b1);
        // Byte counts above four are clamped to a full word.
        push_request(32'hFFFFFFFF, 3'd7, 1'b1);
        push_request(32'h12345678, 3'd5, 1'b0);
        push_request(32'h9ABCDEF0, 3'd6, 1'b0);
        push_request(32'h00000000, 3'd4, 1'b1);
        // Partial words in the middle of a message are packed at byte granularity.
        push_request(32'hA1B2C3D4, 3'd1, 1'b0);
        push_request(32'hE5F60718, 3'd2, 1'b0);
        push_request(32'h293A4B5C, 3'd3, 1'b0);
        push_request(32'h6D7E8F90, 3'd0, 1'b0);
        push_request(32'hFFFFFFFF, 3'd2, 1'b1);
        // Fifty-six bytes leave no room for the length, so two blocks are compressed.
        for (int i = 0; i < 13; i++)
            push_request(i[0] ? 32'h00000000 : 32'hFFFFFFFF, 3'd4, 1'b0);
        push_request(32'hFFFFFFFF, 3'd4, 1'b1);

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            while (req_q.size() > 0) @(posedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            while (sent < PHASE_ITEMS * (ph + 1)) sent += push_random_message();
        end

        while (req_q.size() > 0 || i_in_valid || digest_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("[sm3_hash_top] OK");
        end else begin
            $display("[sm3_hash_top] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sm3_pkg.sv
rtl/sm3_cf.sv
rtl/sm3_hash_top.sv
rtl/sm3_hash_chk.sv
sim/sm3_hash_top_tb.sv
